/* hw/rtl/bsbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbc_pkg
// shared types and constants for the box screen bounds classifier
// ----------------------------------------------------------------------------
package bsbc_pkg;

  localparam int Corners = 8;
  localparam int DotW = 68;   // exact signed width of one matrix row dot product
  localparam int TrkW = 44;   // tracked screen bound width
  localparam logic signed [TrkW-1:0] TrackInit = 44'sh0003FFFFFFF;
  localparam logic signed [TrkW-1:0] SatLimit = 44'sh10000000000;

  localparam logic [1:0] CmdLoadRow = 2'd0;
  localparam logic [1:0] CmdLoadClip = 2'd1;
  localparam logic [1:0] CmdClassify = 2'd2;

  localparam logic [1:0] VerdictCulled = 2'd0;
  localparam logic [1:0] VerdictVisible = 2'd1;
  localparam logic [1:0] VerdictClip = 2'd2;

  localparam logic [2:0] RegNear = 3'd0;
  localparam logic [2:0] RegFar = 3'd1;
  localparam logic [2:0] RegPersp = 3'd2;
  localparam logic [2:0] RegCx = 3'd3;
  localparam logic [2:0] RegCy = 3'd4;
  localparam logic [2:0] RegWx = 3'd5;
  localparam logic [2:0] RegWy = 3'd6;

  // queued box job from the front part
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic signed [15:0] z0;
    logic signed [15:0] z1;
    logic               reject;
  } job_t;

endpackage

/* hw/rtl/bsbc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbc_front
// accepts input transactions, applies loads, queues classify jobs
// ----------------------------------------------------------------------------
module bsbc_front import bsbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] word0,
  input  logic signed [31:0] word1,
  input  logic signed [31:0] word2,
  input  logic signed [31:0] word3,
  input  logic signed [15:0] word4,
  input  logic signed [15:0] word5,
  input  logic               outside_flag,
  input  logic [30:0]        far_depth,
  input  logic               back_busy,
  output logic signed [31:0] mat [12],
  output logic signed [15:0] clip [4],
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  // two entry job queue
  job_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       acc, push, pop, is_load;

  // loads wait for queued and running jobs so they never see a new matrix
  assign is_load = (command == CmdLoadRow) || (command == CmdLoadClip);
  assign in_ready = is_load ? (cnt == 2'd0 && !back_busy) : (cnt != 2'd2);
  assign acc = in_valid && in_ready;
  assign push = acc && (command == CmdClassify);
  assign pop = job_valid && job_ready;
  assign job_valid = cnt != 2'd0;
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
      for (int i = 0; i < 12; i++) mat[i] <= '0;
      for (int i = 0; i < 4; i++) clip[i] <= '0;
    end else begin
      if (push) begin
        q[wp].x0 <= word0;
        q[wp].x1 <= word1;
        q[wp].y0 <= word2;
        q[wp].y1 <= word3;
        q[wp].z0 <= word4;
        q[wp].z1 <= word5;
        q[wp].reject <= !outside_flag && (mat[11] >= $signed({1'b0, far_depth}));
        wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (acc && command == CmdLoadRow && row_index != 2'd3) begin
        mat[{row_index, 2'd0}] <= word0;
        mat[{row_index, 2'd1}] <= word1;
        mat[{row_index, 2'd2}] <= word2;
        mat[{row_index, 2'd3}] <= word3;
      end
      if (acc && command == CmdLoadClip) begin
        clip[0] <= word0[15:0];
        clip[1] <= word1[15:0];
        clip[2] <= word2[15:0];
        clip[3] <= word3[15:0];
      end
    end
  end

endmodule

/* hw/rtl/bsbc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbc_div
// radix-2 restoring divider, unsigned 64 by 64 bit, one quotient bit a cycle
// ----------------------------------------------------------------------------
module bsbc_div import bsbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem, den;
  logic [64:0] trial;
  logic [6:0]  left;
  logic        busy;

  assign trial = {rem[63:0], quotient[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quotient <= dividend;
        den <= divisor;
        left <= 7'd64;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        left <= left - 7'd1;
        if (left == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/bsbc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbc_back
// culls a rejected box, else walks its eight corners, projects those in depth range and decides
// ----------------------------------------------------------------------------
module bsbc_back import bsbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  input  logic signed [31:0] mat [12],
  input  logic signed [15:0] clip [4],
  input  logic [30:0]        near_depth,
  input  logic [30:0]        far_depth,
  input  logic [15:0]        persp_divisor,
  input  logic [11:0]        center_x,
  input  logic [11:0]        center_y,
  input  logic [11:0]        window_x_max,
  input  logic [11:0]        window_y_max,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         verdict
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_SUM   = 10'b0000000100,
    S_ZCHK  = 10'b0000001000,
    S_DZ    = 10'b0000010000,
    S_DX    = 10'b0000100000,
    S_DY    = 10'b0001000000,
    S_NEXT  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  job_t   jb;
  logic [2:0] corner;
  logic [1:0] row;          // row being summed: 2, then 0, then 1
  logic [3:0] count;
  logic signed [31:0] px, py;
  logic signed [15:0] pz;
  logic signed [63:0] m0, m1, m2;
  logic signed [DotW-1:0] dot;
  logic signed [TrkW-1:0] xmin, xmax, ymin, ymax, val;
  logic [63:0] pd;
  logic [63:0] dvd, dvs;
  logic dstart, ddone;
  logic [63:0] q;
  logic dneg;
  logic [63:0] mag;
  logic signed [TrkW-1:0] sx0, sx1, sy0, sy1;

  assign px = (corner[0] ^ corner[1]) ? jb.x1 : jb.x0;
  assign py = corner[1] ? jb.y1 : jb.y0;
  assign pz = corner[2] ? jb.z1 : jb.z0;
  assign job_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign mag = dot[DotW-1] ? 64'(-dot) : 64'(dot);

  bsbc_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quotient(q)
  );

  always_comb begin
    if (q > 64'(SatLimit)) val = SatLimit;
    else val = TrkW'(q);
    if (dneg) val = -val;
  end

  assign sx0 = xmin + TrkW'(center_x);
  assign sx1 = xmax + TrkW'(center_x);
  assign sy0 = ymin + TrkW'(center_y);
  assign sy1 = ymax + TrkW'(center_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            jb <= job;
            corner <= '0;
            count <= '0;
            row <= 2'd2;
            xmin <= TrackInit; xmax <= -TrackInit;
            ymin <= TrackInit; ymax <= -TrackInit;
            if (job.reject) begin
              verdict <= VerdictCulled;
              state <= S_OUT;
            end else state <= S_MUL;
          end
        end
        S_MUL: begin
          m0 <= 64'(px) * 64'(mat[{row, 2'd0}]);
          m1 <= 64'(py) * 64'(mat[{row, 2'd1}]);
          m2 <= 64'(pz) * 64'(mat[{row, 2'd2}]);
          state <= S_SUM;
        end
        S_SUM: begin
          dot <= DotW'(m0) + DotW'(m1) + DotW'(m2) + DotW'(mat[{row, 2'd3}]);
          state <= (row == 2'd2) ? S_ZCHK : ((row == 2'd0) ? S_DX : S_DY);
        end
        S_ZCHK: begin
          if (!dot[DotW-1] && dot < (DotW'(1) <<< 62) &&
              dot > DotW'({1'b0, near_depth}) && dot < DotW'({1'b0, far_depth})) begin
            count <= count + 4'd1;
            dvd <= dot[63:0];
            dvs <= (persp_divisor == 16'd0) ? 64'd1 : 64'(persp_divisor);
            dstart <= 1'b1;
            state <= S_DZ;
          end else state <= S_NEXT;
        end
        S_DZ: begin
          if (ddone) begin
            pd <= (q == 64'd0) ? 64'd1 : q;
            dvs <= '0;
            row <= 2'd0;
            state <= S_MUL;
          end
        end
        S_DX, S_DY: begin
          if (!dstart && !ddone && dvs != pd) begin
            dvd <= mag; dvs <= pd; dneg <= dot[DotW-1]; dstart <= 1'b1;
          end else if (ddone) begin
            dvs <= '0;
            if (state == S_DX) begin
              if (val < xmin) xmin <= val;
              if (val > xmax) xmax <= val;
              row <= 2'd1;
              state <= S_MUL;
            end else begin
              if (val < ymin) ymin <= val;
              if (val > ymax) ymax <= val;
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          row <= 2'd2;
          corner <= corner + 3'd1;
          state <= (corner == 3'd7) ? S_FIN : S_MUL;
        end
        S_FIN: begin
          if (count != 4'd8 || sx0 < 0 || sy0 < 0 ||
              sx1 > TrkW'(window_x_max) || sy1 > TrkW'(window_y_max))
            verdict <= VerdictClip;
          else if (sx0 > TrkW'(clip[2]) || sy0 > TrkW'(clip[3]) ||
                   sx1 < TrkW'(clip[0]) || sy1 < TrkW'(clip[1]))
            verdict <= VerdictCulled;
          else verdict <= VerdictVisible;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/box_screen_bounds_classifier.sv */
`timescale 1ns / 1ps
// per corner in depth range the back part runs three divisions (depth, x and y) on the
// shared one-bit-a-cycle divider; a box rejected on far distance skips the corner walk
// throughput: one box at a time in the back part; a two-entry queue lets input run ahead
// load transactions are accepted once no box is queued or in progress
// reset: synchronous, clears matrix, clip rectangle, queue and registers to defaults
// ----------------------------------------------------------------------------
// box_screen_bounds_classifier
// classifies an object box against the view as culled, visible or clipped
// ----------------------------------------------------------------------------
module box_screen_bounds_classifier import bsbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] word0,
  input  logic signed [31:0] word1,
  input  logic signed [31:0] word2,
  input  logic signed [31:0] word3,
  input  logic signed [15:0] word4,
  input  logic signed [15:0] word5,
  input  logic               outside_flag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         verdict
);

  logic [30:0] near_depth, far_depth;
  logic [15:0] persp_divisor;
  logic [11:0] center_x, center_y, window_x_max, window_y_max;
  logic signed [31:0] mat [12];
  logic signed [15:0] clip [4];
  logic job_valid, job_ready, back_busy;
  job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_depth <= '0;
      far_depth <= 31'h7FFFFFFF;
      persp_divisor <= 16'd1;
      center_x <= '0;
      center_y <= '0;
      window_x_max <= 12'd4095;
      window_y_max <= 12'd4095;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegNear:  near_depth <= cfg_data[30:0];
        RegFar:   far_depth <= cfg_data[30:0];
        RegPersp: persp_divisor <= cfg_data[15:0];
        RegCx:    center_x <= cfg_data[11:0];
        RegCy:    center_y <= cfg_data[11:0];
        RegWx:    window_x_max <= cfg_data[11:0];
        RegWy:    window_y_max <= cfg_data[11:0];
        default:  ;
      endcase
    end
  end

  bsbc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .row_index(row_index), .word0(word0), .word1(word1),
    .word2(word2), .word3(word3), .word4(word4), .word5(word5),
    .outside_flag(outside_flag), .far_depth(far_depth), .back_busy(back_busy),
    .mat(mat), .clip(clip), .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  bsbc_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .mat(mat), .clip(clip), .near_depth(near_depth), .far_depth(far_depth),
    .persp_divisor(persp_divisor), .center_x(center_x), .center_y(center_y),
    .window_x_max(window_x_max), .window_y_max(window_y_max), .busy(back_busy),
    .out_valid(out_valid), .out_ready(out_ready), .verdict(verdict)
  );

endmodule

/* dv/box_screen_bounds_classifier_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_screen_bounds_classifier_checker
// watches the config, input and verdict channels, keeps its own copy of the
// view state and compares every verdict with the predicted one in order
// ----------------------------------------------------------------------------
module box_screen_bounds_classifier_checker import bsbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         command,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] word0,
  input  logic signed [31:0] word1,
  input  logic signed [31:0] word2,
  input  logic signed [31:0] word3,
  input  logic signed [15:0] word4,
  input  logic signed [15:0] word5,
  input  logic               outside_flag,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         verdict,
  output int                 errors,
  output int                 pending
);

  logic signed [31:0] mtx [12];
  logic signed [15:0] clip_rect [4];
  logic [30:0] near_d, far_d;
  logic [15:0] persp;
  logic [11:0] cx, cy, wx, wy;
  logic [1:0]  verdict_q [$];

  assign pending = verdict_q.size();

  // exact row of the view matrix applied to one corner
  function automatic logic signed [67:0] row_dot(int r, logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [15:0] pz);
    logic signed [67:0] ex, ey, ez;
    ex = px;
    ey = py;
    ez = pz;
    return ex * mtx[r*4] + ey * mtx[r*4+1] + ez * mtx[r*4+2] + mtx[r*4+3];
  endfunction

  function automatic longint proj_div(logic signed [67:0] d, logic [67:0] pd);
    logic [67:0] mag, q;
    mag = d[67] ? -d : d;
    q = mag / pd;
    if (q > 68'h100_0000_0000) q = 68'h100_0000_0000;
    return d[67] ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [1:0] classify_box(logic signed [31:0] x0, x1, y0, y1,
                                              logic signed [15:0] z0, z1,
                                              logic flag);
    longint xmin, xmax, ymin, ymax, x, y;
    logic signed [67:0] dz;
    logic [67:0] z, pd;
    int cnt;
    logic signed [31:0] px, py;
    logic signed [15:0] pz;
    xmin = 64'sh3FFF_FFFF; xmax = -64'sh3FFF_FFFF;
    ymin = 64'sh3FFF_FFFF; ymax = -64'sh3FFF_FFFF;
    cnt = 0;
    if (longint'(mtx[11]) >= longint'({1'b0, far_d}) && !flag) return VerdictCulled;
    for (int c = 0; c < Corners; c++) begin
      px = ((c + 1) >> 1) & 1 ? x1 : x0;
      py = (c >> 1) & 1 ? y1 : y0;
      pz = (c >> 2) & 1 ? z1 : z0;
      dz = row_dot(2, px, py, pz);
      if (dz[67] || dz >= 68'sh4000_0000_0000_0000) continue;
      z = dz;
      if (!(z > near_d && z < far_d)) continue;
      cnt++;
      pd = z / (persp == 0 ? 68'd1 : 68'(persp));
      if (pd == 0) pd = 1;
      x = proj_div(row_dot(0, px, py, pz), pd);
      y = proj_div(row_dot(1, px, py, pz), pd);
      if (x < xmin) xmin = x;
      if (x > xmax) xmax = x;
      if (y < ymin) ymin = y;
      if (y > ymax) ymax = y;
    end
    xmin += cx; xmax += cx;
    ymin += cy; ymax += cy;
    if (cnt < Corners || xmin < 0 || ymin < 0 || xmax > wx || ymax > wy)
      return VerdictClip;
    if (xmin > clip_rect[2] || ymin > clip_rect[3] ||
        xmax < clip_rect[0] || ymax < clip_rect[1])
      return VerdictCulled;
    return VerdictVisible;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 12; i++) mtx[i] = '0;
      for (int i = 0; i < 4; i++) clip_rect[i] = '0;
      near_d = '0; far_d = '1; persp = 16'd1;
      cx = '0; cy = '0; wx = '1; wy = '1;
      verdict_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegNear:  near_d = cfg_data[30:0];
          RegFar:   far_d = cfg_data[30:0];
          RegPersp: persp = cfg_data[15:0];
          RegCx:    cx = cfg_data[11:0];
          RegCy:    cy = cfg_data[11:0];
          RegWx:    wx = cfg_data[11:0];
          RegWy:    wy = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (command)
          CmdLoadRow: if (row_index < 3) begin
            mtx[row_index*4] = word0;
            mtx[row_index*4+1] = word1;
            mtx[row_index*4+2] = word2;
            mtx[row_index*4+3] = word3;
          end
          CmdLoadClip: begin
            clip_rect[0] = word0[15:0];
            clip_rect[1] = word1[15:0];
            clip_rect[2] = word2[15:0];
            clip_rect[3] = word3[15:0];
          end
          CmdClassify:
            verdict_q.push_back(classify_box(word0, word1, word2, word3, word4, word5,
                                             outside_flag));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict transaction with nothing expected: verdict=%0d", verdict);
          errors++;
        end else begin
          logic [1:0] exp_v;
          exp_v = verdict_q.pop_front();
          if (verdict !== exp_v) begin
            $error("verdict mismatch: expected %0d actual %0d", exp_v, verdict);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* dv/box_screen_bounds_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_screen_bounds_classifier_tb
// drives matrix, clip and box transactions through several register settings
// with bursty input and stalling output; the checker predicts every verdict
// ----------------------------------------------------------------------------
module box_screen_bounds_classifier_tb;
  import bsbc_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = '0;
  logic [1:0]         row_index = '0;
  logic signed [31:0] word0 = '0, word1 = '0, word2 = '0, word3 = '0;
  logic signed [15:0] word4 = '0, word5 = '0;
  logic               outside_flag = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         verdict;
  int                 errors, pending;
  logic               hold_req = 1'b0;
  int                 burst_left = 0;

  always #4 clk = ~clk;

  box_screen_bounds_classifier u_top (.*);
  box_screen_bounds_classifier_checker u_chk (.*);

  // receiver: alternating stall patterns, plus one long hold-off on request
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (4000) @(negedge clk);
        hold_req = 1'b0;
      end
      cyc++;
      case ((cyc / 300) % 3)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        default: out_ready = ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // valid stays up across back-to-back transactions inside a burst
  task automatic send(logic [1:0] cmd, logic [1:0] row, logic [31:0] w0, w1, w2, w3,
                      logic [15:0] w4, w5, logic flag);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid = 1'b1; command = cmd; row_index = row;
    word0 = w0; word1 = w1; word2 = w2; word3 = w3; word4 = w4; word5 = w5;
    outside_flag = flag;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (2000) @(negedge clk);
  endtask

  function automatic logic [31:0] small_val(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_item;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom);
    else if (r < 16)
      send(CmdLoadRow, 2'd0, $urandom_range(1, 256), small_val(8), small_val(8),
           small_val(50000), 0, 0, 0);
    else if (r < 22)
      send(CmdLoadRow, 2'd1, small_val(8), $urandom_range(1, 256), small_val(8),
           small_val(50000), 0, 0, 0);
    else if (r < 28)
      send(CmdLoadRow, 2'd2, small_val(4), small_val(4), $urandom_range(1, 512),
           $urandom_range(0, 3000000), 0, 0, 0);
    else if (r < 34)
      send(CmdLoadClip, 2'd0, $urandom_range(0, 2500), $urandom_range(0, 2500),
           $urandom_range(1500, 4095), $urandom_range(1500, 4095), 0, 0, 0);
    else if (r < 40)
      send(CmdClassify, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
    else
      send(CmdClassify, $urandom, small_val(2000), small_val(2000), small_val(2000),
           small_val(2000), small_val(2000), small_val(2000), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    #60ms;
    $display("FAIL box_screen_bounds_classifier");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_reg(RegNear, 32'd0);
    write_reg(RegFar, 32'h7FFF_FFFF);
    write_reg(RegPersp, 32'd1000);
    write_reg(RegCx, 32'd2048);
    write_reg(RegCy, 32'd2048);
    write_reg(RegWx, 32'd4095);
    write_reg(RegWy, 32'd4095);
    write_reg(3'd7, 32'hFFFF_FFFF);

    // directed: plain view, visible box, clip culling, far rejection and friends
    send(CmdLoadRow, 2'd0, 32'd16, 0, 0, 0, 0, 0, 0);
    send(CmdLoadRow, 2'd1, 0, 32'd16, 0, 0, 0, 0, 0);
    send(CmdLoadRow, 2'd2, 0, 0, 32'd10, 32'd1000000, 0, 0, 0);
    send(CmdLoadClip, 2'd0, 32'd0, 32'd0, 32'd4095, 32'd4095, 0, 0, 0);
    send(CmdClassify, 0, -32'sd100, 32'sd100, -32'sd100, 32'sd100, -16'sd10, 16'sd10, 0);
    send(CmdLoadClip, 2'd0, 32'd3000, 32'd3000, 32'd4000, 32'd4000, 0, 0, 0);
    send(CmdClassify, 0, -32'sd100, 32'sd100, -32'sd100, 32'sd100, -16'sd10, 16'sd10, 0);
    send(CmdLoadClip, 2'd0, 32'hABCD_F000, 32'h1234_8000, 32'h0000_7FFF, 32'hFFFF_0FFF,
         0, 0, 0);
    send(CmdClassify, 0, 32'sd5000, 32'sd9000, 32'sd0, 32'sd10, 0, 0, 0);
    send(CmdClassify, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         16'h8000, 16'h7FFF, 1);
    send(CmdClassify, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 0);
    send(CmdLoadRow, 2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         0, 0, 0);
    send(2'd3, 2'd0, 1, 2, 3, 4, 5, 6, 1);
    send(CmdLoadRow, 2'd2, 0, 0, 32'd1, 32'h7FFF_FFFF, 0, 0, 0);
    send(CmdClassify, 0, 0, 32'd1, 0, 32'd1, 0, 16'd1, 0);
    send(CmdClassify, 0, 0, 32'd1, 0, 32'd1, 0, 16'd1, 1);
    send(CmdLoadRow, 2'd2, 0, 0, 0, 32'd200, 0, 0, 0);
    send(CmdClassify, 0, -32'sd3, 32'sd3, -32'sd3, 32'sd3, 0, 0, 0);
    send(CmdLoadRow, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         0, 0, 0);
    send(CmdLoadRow, 2'd2, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
    send(CmdClassify, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1);
    send(CmdLoadRow, 2'd2, 0, 0, 32'd10, 32'd1000000, 0, 0, 0);
    send(CmdClassify, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegNear, 32'd0); write_reg(RegFar, 32'h7FFF_FFFF);
          write_reg(RegPersp, 32'd0);
          write_reg(RegCx, 32'd0); write_reg(RegCy, 32'd0);
          write_reg(RegWx, 32'd4095); write_reg(RegWy, 32'd4095);
        end
        1: begin
          write_reg(RegNear, 32'h7FFF_FFFF); write_reg(RegFar, 32'h0);
          write_reg(RegPersp, 32'hFFFF);
          write_reg(RegCx, 32'd4095); write_reg(RegCy, 32'd4095);
          write_reg(RegWx, 32'd0); write_reg(RegWy, 32'd0);
        end
        default: begin
          write_reg(RegNear, $urandom_range(0, 200000));
          write_reg(RegFar, $urandom_range(500000, 3500000));
          write_reg(RegPersp, $urandom_range(1, 4000));
          write_reg(RegCx, $urandom_range(1000, 3000));
          write_reg(RegCy, $urandom_range(1000, 3000));
          write_reg(RegWx, $urandom_range(2500, 4095));
          write_reg(RegWy, $urandom_range(2500, 4095));
        end
      endcase
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < (ph == 1 ? 40 : 150); i++) random_item();
      drain();
    end

    if (errors == 0)
      $display("PASS box_screen_bounds_classifier");
    else
      $display("FAIL box_screen_bounds_classifier");
    $finish;
  end

endmodule
